// ===== design/ppmhp_pkg.sv =====
// shared types, codes and constants for the p6 header parser
// no dependencies; imported by every module
`default_nettype none

package ppmhp_pkg;

   // chunk length limit and value width
   localparam int LINE_CHUNK  = 70;
   localparam int VALUE_BITS  = 16;
   localparam int ACC_BITS    = VALUE_BITS + 1;
   localparam int POS_BITS    = 7;

   // field codes
   localparam logic [2:0] FS_MAGIC  = 3'd0;
   localparam logic [2:0] FS_WIDTH  = 3'd1;
   localparam logic [2:0] FS_HEIGHT = 3'd2;
   localparam logic [2:0] FS_MAXVAL = 3'd3;
   localparam logic [2:0] FS_DONE   = 3'd4;

   // token phase codes
   localparam logic [2:0] TP_BETWEEN = 3'd0;
   localparam logic [2:0] TP_MAGIC   = 3'd1;
   localparam logic [2:0] TP_SIGN    = 3'd2;
   localparam logic [2:0] TP_DIGITS  = 3'd3;
   localparam logic [2:0] TP_JUNK    = 3'd4;

   // status codes
   localparam logic [1:0] ST_PARSING  = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_P     = 8'h50;

   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(LINE_CHUNK - 1);
   localparam logic [ACC_BITS-1:0] ACC_CAP  = ACC_BITS'(1) << VALUE_BITS;

   typedef struct packed {
      logic [2:0]            field_state;
      logic [POS_BITS-1:0]   chunk_position;
      logic                  comment_chunk;
      logic [2:0]            token_phase;
      logic [1:0]            magic_match;
      logic [ACC_BITS-1:0]   value_accumulator;
      logic                  value_negative;
      logic [VALUE_BITS-1:0] held_width;
      logic [VALUE_BITS-1:0] held_height;
      logic [VALUE_BITS-1:0] held_maxval;
      logic [1:0]            parse_status;
   } parser_state_type;

   localparam parser_state_type STATE_RESET = '{
      field_state:       FS_MAGIC,
      chunk_position:    '0,
      comment_chunk:     1'b0,
      token_phase:       TP_BETWEEN,
      magic_match:       2'd0,
      value_accumulator: '0,
      value_negative:    1'b0,
      held_width:        '0,
      held_height:       '0,
      held_maxval:       '0,
      parse_status:      ST_PARSING
   };

endpackage

`default_nettype wire

// ===== design/ppmhp_req_if.sv =====
// byte input channel: valid/ready handshake with one stream byte
// depends on nothing
`default_nettype none

interface ppmhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== design/ppmhp_rsp_if.sv =====
// result channel: status and the three header values
// depends on nothing
`default_nettype none

interface ppmhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [15:0] max_value;

   modport source (output valid, output status, output image_width,
                   output image_height, output max_value, input ready);
   modport sink   (input valid, input status, input image_width,
                   input image_height, input max_value, output ready);
endinterface

`default_nettype wire

// ===== design/ppmhp_step.sv =====
// next-state logic of the parser for one byte
// depends on ppmhp_pkg
`default_nettype none

module ppmhp_step (
   input  ppmhp_pkg::parser_state_type cur_state,
   input  logic [7:0]                  data_byte,
   input  logic                        stream_end,
   output ppmhp_pkg::parser_state_type nxt_state
);
   import ppmhp_pkg::*;

   parser_state_type      ended;
   parser_state_type      tokened;
   parser_state_type      work;
   logic                  is_digit;
   logic                  is_blank;
   logic                  last;
   logic                  comment;
   logic [VALUE_BITS-1:0] sat_value;
   logic [ACC_BITS+3:0]   digit_sum;
   logic [ACC_BITS-1:0]   digit_acc;

   assign is_digit = data_byte inside {[CH_ZERO:CH_NINE]};
   assign is_blank = data_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
   assign last     = (cur_state.chunk_position >= POS_LAST);
   assign comment  = (cur_state.chunk_position == '0) ? (data_byte == CH_HASH)
                                                       : cur_state.comment_chunk;

   // accumulator times ten plus digit, capped just above the value range
   assign digit_sum = ({1'b0, cur_state.value_accumulator, 3'b000})
                    + ({3'b000, cur_state.value_accumulator, 1'b0})
                    + (ACC_BITS+4)'(data_byte - CH_ZERO);
   assign digit_acc = (digit_sum > (ACC_BITS+4)'(ACC_CAP)) ? ACC_CAP
                                                           : digit_sum[ACC_BITS-1:0];

   // token value with negative and overflow saturation
   always_comb begin
      if (cur_state.value_negative) begin
         sat_value = '0;
      end else if (cur_state.value_accumulator[ACC_BITS-1]) begin
         sat_value = '1;
      end else begin
         sat_value = cur_state.value_accumulator[VALUE_BITS-1:0];
      end
   end

   // close the current token
   always_comb begin
      ended = cur_state;
      if (cur_state.token_phase == TP_MAGIC) begin
         if (cur_state.magic_match == 2'd2) begin
            ended.field_state = FS_WIDTH;
         end else begin
            ended.parse_status = ST_ERROR;
         end
      end else if (cur_state.token_phase != TP_BETWEEN) begin
         case (cur_state.field_state)
            FS_WIDTH: begin
               ended.held_width  = sat_value;
               ended.field_state = FS_HEIGHT;
            end
            FS_HEIGHT: begin
               ended.held_height = sat_value;
               ended.field_state = FS_MAXVAL;
            end
            FS_MAXVAL: begin
               ended.held_maxval = sat_value;
               ended.field_state = FS_DONE;
            end
            default: begin
            end
         endcase
      end
      ended.token_phase       = TP_BETWEEN;
      ended.magic_match       = 2'd0;
      ended.value_accumulator = '0;
      ended.value_negative    = 1'b0;
   end

   // ordinary token character
   always_comb begin
      tokened = cur_state;
      if (cur_state.field_state < FS_DONE) begin
         case (cur_state.token_phase)
            TP_BETWEEN: begin
               if (cur_state.field_state == FS_MAGIC) begin
                  tokened.token_phase = TP_MAGIC;
                  if (data_byte == CH_P) begin
                     tokened.magic_match = 2'd1;
                  end else begin
                     tokened.parse_status = ST_ERROR;
                  end
               end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
                  tokened.token_phase    = TP_SIGN;
                  tokened.value_negative = (data_byte == CH_MINUS);
               end else if (is_digit) begin
                  tokened.token_phase       = TP_DIGITS;
                  tokened.value_accumulator = digit_acc;
               end else begin
                  tokened.token_phase = TP_JUNK;
               end
            end
            TP_MAGIC: begin
               if (cur_state.magic_match == 2'd1 && data_byte == CH_SIX) begin
                  tokened.magic_match = 2'd2;
               end else begin
                  tokened.parse_status = ST_ERROR;
               end
            end
            TP_SIGN, TP_DIGITS: begin
               if (is_digit) begin
                  tokened.token_phase       = TP_DIGITS;
                  tokened.value_accumulator = digit_acc;
               end else begin
                  tokened.token_phase = TP_JUNK;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // byte dispatch
   always_comb begin
      work = cur_state;
      if (cur_state.parse_status == ST_PARSING) begin
         work.comment_chunk = comment;
         if (comment) begin
            work.chunk_position = (data_byte == CH_LF || last)
                                ? '0 : cur_state.chunk_position + POS_BITS'(1);
         end else if (data_byte == CH_NUL) begin
            work.parse_status = ST_ERROR;
         end else if (data_byte == CH_LF) begin
            if (cur_state.field_state < FS_DONE) begin
               work = ended;
               work.comment_chunk = comment;
            end
            if (work.parse_status == ST_PARSING) begin
               if (work.field_state == FS_MAGIC) begin
                  work.parse_status = ST_ERROR;
               end else if (work.field_state >= FS_DONE) begin
                  work.parse_status = ST_COMPLETE;
               end
            end
            work.chunk_position = '0;
            work.token_phase    = TP_BETWEEN;
         end else begin
            if (is_blank) begin
               if (cur_state.field_state < FS_DONE) begin
                  work = ended;
               end
            end else begin
               work = tokened;
            end
            work.comment_chunk = comment;
            if (last) begin
               work.parse_status = ST_ERROR;
            end else begin
               work.chunk_position = cur_state.chunk_position + POS_BITS'(1);
            end
         end
         if (stream_end && work.parse_status == ST_PARSING) begin
            work.parse_status = ST_ERROR;
         end
      end
      nxt_state = work;
   end

endmodule

`default_nettype wire

// ===== design/ppm_binary_header_parser_core.sv =====
// top level of the p6 header parser: input register, step logic, result register
// depends on ppmhp_pkg, ppmhp_req_if, ppmhp_rsp_if and ppmhp_step
//
//   channel   direction  transaction
//   req_ch    in         one stream byte with its end-of-stream flag
//   rsp_ch    out        status and held width, height, maxval after that byte
//
// one byte per cycle sustained while the result side does not stall; an accepted byte passes
// the input register, then the step logic into the result register
// the parser state advances in the same cycle a byte moves into the result register,
// so the next byte in the input register sees it at once
// synchronous active-high reset returns the parser to expecting the magic token
// a stalled result holds both registers; req ready drops only when both are full
// and the result is not being taken
`default_nettype none

module ppm_binary_header_parser_core (
   input  wire logic   clock,
   input  wire logic   reset,
   ppmhp_req_if.sink   req_ch,
   ppmhp_rsp_if.source rsp_ch
);
   import ppmhp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // parser state
   parser_state_type state_ff, state_in;
   parser_state_type step_out;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_width_ff;
   logic [VALUE_BITS-1:0] rsp_height_ff;
   logic [VALUE_BITS-1:0] rsp_maxval_ff;

   logic advance;
   logic take;

   // byte moves forward when the result register is free or being drained
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   ppmhp_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .stream_end (in_end_ff),
      .nxt_state  (step_out)
   );

   assign state_in     = advance ? step_out : state_ff;
   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_ch.data_byte;
         in_end_ff  <= req_ch.stream_end;
      end
      if (advance) begin
         rsp_status_ff <= step_out.parse_status;
         rsp_width_ff  <= step_out.held_width;
         rsp_height_ff <= step_out.held_height;
         rsp_maxval_ff <= step_out.held_maxval;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.image_width  = rsp_width_ff;
   assign rsp_ch.image_height = rsp_height_ff;
   assign rsp_ch.max_value    = rsp_maxval_ff;

endmodule

`default_nettype wire

// ===== sim/tb_ppm_binary_header_parser_core.sv =====
// testbench for ppm_binary_header_parser_core: streams one p6 header with random filler,
// predicts status and held values per byte, checks every result transaction in order
// depends on ppmhp_pkg, ppmhp_req_if, ppmhp_rsp_if and the core itself

module tb_ppm_binary_header_parser_core;
   import ppmhp_pkg::*;

   // bench constants
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          DRAIN_CYCLES   = 10;
   localparam int          REPORT_LIMIT   = 10;
   localparam int          PHASE_LEN      = 40;
   localparam int          IDLE_HEAVY     = 81;
   localparam int          IDLE_LIGHT     = 14;
   localparam int          ITEM_TARGET    = 600;
   localparam int unsigned VALUE_LIMIT    = (1 << VALUE_BITS) - 1;
   localparam logic [7:0]  CH_LOWER_A     = 8'h61;
   localparam logic [7:0]  HIGH_BYTE_BASE = 8'h80;

   // how the single header of this run ends; the seed picks one
   typedef enum {
      RUN_COMPLETE, RUN_NO_NEWLINE, RUN_ZERO_BYTE, RUN_EARLY_END,
      RUN_BLANK_MAGIC, RUN_BAD_MAGIC
   } run_mode_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] width;
      logic [VALUE_BITS-1:0] height;
      logic [VALUE_BITS-1:0] maxval;
   } header_report_type;

   logic clock = 1'b0;
   logic reset;

   ppmhp_req_if req_ch ();
   ppmhp_rsp_if rsp_ch ();

   ppm_binary_header_parser_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   run_mode_type      run_mode;
   header_report_type expected_reports[$];
   int                bytes_sent     = 0;
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                idle_pct       = 0;
   int                stall_pct      = 0;

   // ---------------------------------------------------------------------
   // header parser prediction: a copy of the parser state, advanced per byte
   // ---------------------------------------------------------------------
   logic [2:0]            model_field   = FS_MAGIC;
   logic [POS_BITS-1:0]   model_pos     = '0;
   logic                  model_comment = 1'b0;
   logic [2:0]            model_phase   = TP_BETWEEN;
   logic [1:0]            model_magic   = 2'd0;
   int unsigned           model_acc     = 0;
   logic                  model_neg     = 1'b0;
   logic [VALUE_BITS-1:0] model_width   = '0;
   logic [VALUE_BITS-1:0] model_height  = '0;
   logic [VALUE_BITS-1:0] model_maxval  = '0;
   logic [1:0]            model_status  = ST_PARSING;

   // closes the open token: magic check, or store of the next header value
   function automatic void finish_token();
      int unsigned v;
      if (model_phase == TP_MAGIC) begin
         if (model_magic == 2'd2) model_field = FS_WIDTH;
         else model_status = ST_ERROR;
      end else if (model_phase != TP_BETWEEN) begin
         v = model_neg ? 0 : model_acc;
         if (v > VALUE_LIMIT) v = VALUE_LIMIT;
         case (model_field)
            FS_WIDTH: begin
               model_width = VALUE_BITS'(v);
               model_field = FS_HEIGHT;
            end
            FS_HEIGHT: begin
               model_height = VALUE_BITS'(v);
               model_field  = FS_MAXVAL;
            end
            FS_MAXVAL: begin
               model_maxval = VALUE_BITS'(v);
               model_field  = FS_DONE;
            end
            default: ;
         endcase
      end
      model_phase = TP_BETWEEN;
      model_magic = 2'd0;
      model_acc   = 0;
      model_neg   = 1'b0;
   endfunction

   // accumulate one decimal digit, capped one above the largest value
   function automatic void take_digit(input logic [7:0] c);
      model_acc = model_acc * 10 + (int'(c) - int'(CH_ZERO));
      if (model_acc > VALUE_LIMIT + 1) model_acc = VALUE_LIMIT + 1;
   endfunction

   // a byte inside a line, neither blank nor newline nor zero
   function automatic void token_byte(input logic [7:0] c);
      logic is_num;
      is_num = (c >= CH_ZERO && c <= CH_NINE);
      if (model_field >= FS_DONE) return;
      case (model_phase)
         TP_BETWEEN: begin
            if (model_field == FS_MAGIC) begin
               model_phase = TP_MAGIC;
               if (c == CH_P) model_magic = 2'd1;
               else model_status = ST_ERROR;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               model_phase = TP_SIGN;
               model_neg   = (c == CH_MINUS);
            end else if (is_num) begin
               model_phase = TP_DIGITS;
               take_digit(c);
            end else begin
               model_phase = TP_JUNK;
            end
         end
         TP_MAGIC: begin
            if (model_magic == 2'd1 && c == CH_SIX) model_magic = 2'd2;
            else model_status = ST_ERROR;
         end
         TP_SIGN, TP_DIGITS: begin
            if (is_num) begin
               model_phase = TP_DIGITS;
               take_digit(c);
            end else begin
               model_phase = TP_JUNK;
            end
         end
         default: ;
      endcase
   endfunction

   // chunking, comments, zero bytes and line ends
   function automatic void parse_byte(input logic [7:0] c);
      logic at_limit;
      at_limit = (int'(model_pos) + 1 >= LINE_CHUNK);
      if (model_pos == '0) model_comment = (c == CH_HASH);
      if (model_comment) begin
         model_pos = (c == CH_LF || at_limit) ? '0 : model_pos + POS_BITS'(1);
         return;
      end
      if (c == CH_NUL) begin
         model_status = ST_ERROR;
         return;
      end
      if (c == CH_LF) begin
         if (model_field < FS_DONE) finish_token();
         if (model_status == ST_PARSING) begin
            if (model_field == FS_MAGIC) model_status = ST_ERROR;
            else if (model_field >= FS_DONE) model_status = ST_COMPLETE;
         end
         model_pos   = '0;
         model_phase = TP_BETWEEN;
         return;
      end
      if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF}) begin
         if (model_field < FS_DONE) finish_token();
      end else begin
         token_byte(c);
      end
      if (at_limit) model_status = ST_ERROR;
      else model_pos = model_pos + POS_BITS'(1);
   endfunction

   // result expected for one byte transaction; complete and error are sticky
   function automatic header_report_type predict_report(input logic [7:0] c,
                                                        input logic last);
      if (model_status == ST_PARSING) begin
         parse_byte(c);
         if (last && model_status == ST_PARSING) model_status = ST_ERROR;
      end
      return '{model_status, model_width, model_height, model_maxval};
   endfunction

   // ---------------------------------------------------------------------
   // byte sender with idle phases
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      int phase;
      // rotate through: no idling, sender idle, receiver stalling, both light
      phase = (bytes_sent / PHASE_LEN) % 4;
      case (phase)
         0: begin idle_pct = 0;          stall_pct = 0;          end
         1: begin idle_pct = IDLE_HEAVY; stall_pct = 0;          end
         2: begin idle_pct = 0;          stall_pct = IDLE_HEAVY; end
         default: begin idle_pct = IDLE_LIGHT; stall_pct = IDLE_LIGHT; end
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.stream_end <= last;
      expected_reports.push_back(predict_report(b, last));
      // transaction completes at the first edge that sees ready
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         3:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   // token character that is neither digit nor sign: letter or high byte
   function automatic logic [7:0] junk_char();
      if ($urandom_range(1)) return CH_LOWER_A + 8'($urandom_range(25));
      return HIGH_BYTE_BASE + 8'($urandom_range(127));
   endfunction

   // one value token: plain, boundary, overflow, signed, bare sign, junk-tailed or junk-led
   task automatic send_value_token();
      string      digits;
      logic [7:0] lead;
      int         tail;
      int         i;
      lead   = CH_NUL;   // zero here means no leading character
      tail   = 0;
      digits = $sformatf("%0d", $urandom_range(0, VALUE_LIMIT));
      case ($urandom_range(0, 9))
         1: digits = $sformatf("%0d", $urandom_range(0, 99));
         2: digits = $sformatf("%0d%08d", $urandom_range(1, 9999), $urandom_range(0, 99999999));
         3: begin
            case ($urandom_range(0, 3))
               0:       digits = "65535";
               1:       digits = "65536";
               2:       digits = "0";
               default: digits = "0065535";
            endcase
         end
         4: lead = CH_PLUS;
         5: lead = CH_MINUS;
         6: tail = $urandom_range(1, 3);
         7: lead = junk_char();
         8: begin
            lead   = $urandom_range(1) ? CH_PLUS : CH_MINUS;
            digits = "";
            tail   = $urandom_range(0, 1);
         end
         9: digits = $sformatf("%05d", $urandom_range(0, 999));
         default: ;
      endcase
      if (lead != CH_NUL) send_byte(lead, 1'b0);
      for (i = 0; i < digits.len(); i++) send_byte(digits[i], 1'b0);
      repeat (tail) send_byte(junk_char(), 1'b0);
   endtask

   // line with one to three value tokens; left open when the header ending follows
   task automatic send_value_line(input int count, input bit keep_open);
      int i;
      repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b0);
      for (i = 0; i < count; i++) begin
         if (i > 0) repeat ($urandom_range(1, 3)) send_byte(pick_blank(), 1'b0);
         send_value_token();
      end
      if (!keep_open) begin
         repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b0);
         send_byte(CH_LF, 1'b0);
      end
   endtask

   // line that never advances the header: comment, long comment, blank or empty
   task automatic send_filler_line();
      int         kind;
      int         len;
      int         i;
      logic       in_comment;
      logic [7:0] c;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         send_byte(CH_HASH, 1'b0);
         repeat ($urandom_range(0, 60)) begin
            // any byte but newline; zero bytes are fine inside a comment
            c = 8'($urandom_range(0, 255));
            send_byte((c == CH_LF) ? CH_NUL : c, 1'b0);
         end
      end else if (kind < 7) begin
         // longer than one chunk: each continuation is a comment only if it
         // opens with a hash, otherwise it is a short run of blanks
         len        = $urandom_range(LINE_CHUNK + 1, 3 * LINE_CHUNK);
         in_comment = 1'b1;
         for (i = 0; i < len; i++) begin
            if (i % LINE_CHUNK == 0) begin
               in_comment = (i == 0) || ($urandom_range(3) != 0);
               if (in_comment) begin
                  send_byte(CH_HASH, 1'b0);
               end else begin
                  send_byte(pick_blank(), 1'b0);
                  len = i + $urandom_range(1, 20);
               end
            end else if (in_comment) begin
               c = 8'($urandom_range(0, 255));
               send_byte((c == CH_LF) ? CH_NUL : c, 1'b0);
            end else begin
               send_byte(pick_blank(), 1'b0);
            end
         end
      end else if (kind < 9) begin
         repeat ($urandom_range(1, 8)) send_byte(pick_blank(), 1'b0);
      end
      send_byte(CH_LF, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // comment lines ahead of the magic, zero and all-ones bytes inside them
   task automatic test_leading_comments();
      send_byte(CH_HASH, 1'b0);
      send_byte(CH_NUL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_LF, 1'b0);
      send_byte(CH_HASH, 1'b0);
      send_byte(CH_LF, 1'b0);
   endtask

   // magic line: good, blank before the magic, or a bad magic token
   task automatic test_magic_token();
      case (run_mode)
         RUN_BLANK_MAGIC: begin
            send_byte(CH_SPACE, 1'b0);
            send_byte(CH_TAB, 1'b0);
            send_byte(CH_LF, 1'b0);
         end
         RUN_BAD_MAGIC: begin
            case ($urandom_range(0, 5))
               0: send_text("P");
               1: send_text("P7");
               2: send_text("Q6");
               3: send_text("P66");
               4: send_text("p6");
               default: begin
                  send_byte(8'hD0, 1'b0);
                  send_byte(CH_SIX, 1'b0);
               end
            endcase
            send_byte(CH_LF, 1'b0);
         end
         default: begin
            send_byte(CH_SPACE, 1'b0);
            send_text("P6");
            send_byte(CH_TAB, 1'b0);
            send_byte(CH_CR, 1'b0);
            send_byte(CH_VT, 1'b0);
            send_byte(CH_FF, 1'b0);
            send_byte(CH_LF, 1'b0);
         end
      endcase
   endtask

   // width, height and maxval spread over filler lines; the maxval line stays open
   task automatic test_values_with_filler();
      int values_left;
      int take;
      int next_value_at;
      values_left   = 3;
      next_value_at = bytes_sent + $urandom_range(100, 180);
      while (values_left > 0) begin
         if (bytes_sent >= next_value_at) begin
            take = ($urandom_range(3) == 0) ? $urandom_range(1, values_left) : 1;
            send_value_line(take, take == values_left);
            values_left   -= take;
            next_value_at = bytes_sent + $urandom_range(100, 180);
         end else begin
            send_filler_line();
         end
      end
   endtask

   // how the maxval line ends: newline, chunk overrun, zero byte or early stream end
   task automatic test_header_ending();
      int guard;
      case (run_mode)
         RUN_COMPLETE: begin
            // trailing tokens on the maxval line are ignored
            while (model_pos < 40 && $urandom_range(1)) begin
               send_byte(pick_blank(), 1'b0);
               send_value_token();
            end
            send_byte(CH_LF, 1'($urandom_range(1)));
         end
         RUN_NO_NEWLINE: begin
            guard = 0;
            while (model_status == ST_PARSING && guard < 2 * LINE_CHUNK) begin
               send_byte($urandom_range(1) ? pick_blank() : junk_char(), 1'b0);
               guard++;
            end
         end
         RUN_ZERO_BYTE: begin
            if ($urandom_range(1)) send_byte(pick_blank(), 1'b0);
            send_byte(CH_NUL, 1'b0);
         end
         default: begin
            send_byte($urandom_range(1) ? pick_blank() : CH_ZERO + 8'($urandom_range(9)),
                      1'b1);
         end
      endcase
   endtask

   // after completion or error every byte is ignored and the result holds;
   // these bytes also bring the run up to its full length
   task automatic test_sticky_status();
      repeat (10) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
      while (bytes_sent < ITEM_TARGET)
         send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls and in-order checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      header_report_type seen;
      header_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen = '{rsp_ch.status, rsp_ch.image_width, rsp_ch.image_height, rsp_ch.max_value};
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("result with nothing pending: status=%0d w=%0d h=%0d m=%0d",
                        seen.status, seen.width, seen.height, seen.maxval);
         end else begin
            want = expected_reports.pop_front();
            if (seen.status !== want.status || seen.width !== want.width ||
                seen.height !== want.height || seen.maxval !== want.maxval) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected status=%0d w=%0d h=%0d m=%0d",
                           want.status, want.width, want.height, want.maxval);
                  $display("          got      status=%0d w=%0d h=%0d m=%0d",
                           seen.status, seen.width, seen.height, seen.maxval);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequence: one header per run, since reset is applied only once
   // ---------------------------------------------------------------------
   initial begin
      int pick;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = 8'h00;
      req_ch.stream_end = 1'b0;
      rsp_ch.ready      = 1'b0;

      // early magic failures are rare so most runs go deep into the header
      pick = $urandom_range(0, 11);
      case (pick)
         0:       run_mode = RUN_BLANK_MAGIC;
         1:       run_mode = RUN_BAD_MAGIC;
         2, 3:    run_mode = RUN_NO_NEWLINE;
         4, 5:    run_mode = RUN_ZERO_BYTE;
         6, 7:    run_mode = RUN_EARLY_END;
         default: run_mode = RUN_COMPLETE;
      endcase

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_leading_comments();
      test_magic_token();
      if (run_mode != RUN_BLANK_MAGIC && run_mode != RUN_BAD_MAGIC) begin
         test_values_with_filler();
         test_header_ending();
      end
      test_sticky_status();
      req_ch.valid <= 1'b0;

      // drain, then give the pipeline time to show any stray transaction
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/ppmhp_pkg.sv
design/ppmhp_req_if.sv
design/ppmhp_rsp_if.sv
design/ppmhp_step.sv
design/ppm_binary_header_parser_core.sv
sim/tb_ppm_binary_header_parser_core.sv
